// ----- hdl/cpu_alu_with_flags_defines.svh -----
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_defines
// Assertion macros shared by the ALU top level.
// ----------------------------------------------------------------------------
`ifndef CPU_ALU_WITH_FLAGS_DEFINES_SVH
`define CPU_ALU_WITH_FLAGS_DEFINES_SVH

// Same-cycle implication, off during reset.
`define CAWF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpu_alu_with_flags: same-cycle check failed");

// Next-cycle implication, off during reset.
`define CAWF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpu_alu_with_flags: next-cycle check failed");

`endif

// ----- hdl/cawf_pkg.sv -----
// ----------------------------------------------------------------------------
// cawf_pkg
// Types and constants for the 8-bit ALU with Z/N/H/C flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cawf_pkg;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_ADD16 = 5'd10,
    OP_RLC   = 5'd11,
    OP_RRC   = 5'd12,
    OP_RL    = 5'd13,
    OP_RR    = 5'd14,
    OP_SLA   = 5'd15,
    OP_SRA   = 5'd16,
    OP_SWAP  = 5'd17,
    OP_SRL   = 5'd18,
    OP_BIT   = 5'd19,
    OP_RES   = 5'd20,
    OP_SET   = 5'd21
  } alu_op_t;

  // flags_written bit positions
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  localparam logic [3:0] MASK_NONE = 4'b0000;
  localparam logic [3:0] MASK_ALL  = 4'b1111;
  localparam logic [3:0] MASK_ZNH  = 4'b1110;
  localparam logic [3:0] MASK_NHC  = 4'b0111;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic        carry_in;
  } alu_in_t;

  typedef struct packed {
    logic [15:0] result;
    logic        zero_flag;
    logic        subtract_flag;
    logic        half_carry_flag;
    logic        carry_flag;
    logic [3:0]  flags_written;
  } alu_out_t;

endpackage

// ----- hdl/cawf_core.sv -----
// ----------------------------------------------------------------------------
// cawf_core
// Combinational datapath: one operation, result value and flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cawf_core (
  input  cawf_pkg::alu_in_t  op_i,
  output cawf_pkg::alu_out_t res_o
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic        adc_cin;
  logic        sbc_cin;
  logic [8:0]  sum8;
  logic [4:0]  sum4;
  logic [8:0]  diff8;
  logic [4:0]  diff4;
  logic [16:0] sum16;
  logic [12:0] sum12;
  logic [7:0]  bit_sel;

  logic [15:0] res;
  logic        z;
  logic        n;
  logic        h;
  logic        c;
  logic [3:0]  mask;

  assign a       = op_i.operand_a[7:0];
  assign b       = op_i.operand_b[7:0];
  assign adc_cin = (op_i.kind == cawf_pkg::OP_ADC) & op_i.carry_in;
  assign sbc_cin = (op_i.kind == cawf_pkg::OP_SBC) & op_i.carry_in;
  assign bit_sel = 8'b1 << op_i.bit_index;

  assign sum8  = {1'b0, a} + {1'b0, b} + {8'd0, adc_cin};
  assign sum4  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, adc_cin};
  // Top bit of the 9/5-bit difference is the borrow
  assign diff8 = {1'b0, a} - {1'b0, b} - {8'd0, sbc_cin};
  assign diff4 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, sbc_cin};
  assign sum16 = {1'b0, op_i.operand_a} + {1'b0, op_i.operand_b};
  assign sum12 = {1'b0, op_i.operand_a[11:0]} + {1'b0, op_i.operand_b[11:0]};

  always_comb begin
    res  = 16'd0;
    z    = 1'b0;
    n    = 1'b0;
    h    = 1'b0;
    c    = 1'b0;
    mask = cawf_pkg::MASK_ALL;
    unique case (op_i.kind) inside
      cawf_pkg::OP_ADD, cawf_pkg::OP_ADC: begin
        res = {8'd0, sum8[7:0]};
        h   = sum4[4];
        c   = sum8[8];
      end
      cawf_pkg::OP_SUB, cawf_pkg::OP_SBC: begin
        res = {8'd0, diff8[7:0]};
        n   = 1'b1;
        h   = diff4[4];
        c   = diff8[8];
      end
      cawf_pkg::OP_CP: begin
        res = {8'd0, a};
        n   = 1'b1;
        h   = diff4[4];
        c   = diff8[8];
      end
      cawf_pkg::OP_AND: begin
        res = {8'd0, a & b};
        h   = 1'b1;
      end
      cawf_pkg::OP_XOR: res = {8'd0, a ^ b};
      cawf_pkg::OP_OR:  res = {8'd0, a | b};
      cawf_pkg::OP_INC: begin
        res  = {8'd0, a + 8'd1};
        h    = (a[3:0] == 4'hF);
        mask = cawf_pkg::MASK_ZNH;
      end
      cawf_pkg::OP_DEC: begin
        res  = {8'd0, a - 8'd1};
        n    = 1'b1;
        h    = (a[3:0] == 4'h0);
        mask = cawf_pkg::MASK_ZNH;
      end
      cawf_pkg::OP_ADD16: begin
        res  = sum16[15:0];
        h    = sum12[12];
        c    = sum16[16];
        mask = cawf_pkg::MASK_NHC;
      end
      cawf_pkg::OP_RLC: begin
        res = {8'd0, a[6:0], a[7]};
        c   = a[7];
      end
      cawf_pkg::OP_RRC: begin
        res = {8'd0, a[0], a[7:1]};
        c   = a[0];
      end
      cawf_pkg::OP_RL: begin
        res = {8'd0, a[6:0], op_i.carry_in};
        c   = a[7];
      end
      cawf_pkg::OP_RR: begin
        res = {8'd0, op_i.carry_in, a[7:1]};
        c   = a[0];
      end
      cawf_pkg::OP_SLA: begin
        res = {8'd0, a[6:0], 1'b0};
        c   = a[7];
      end
      cawf_pkg::OP_SRA: begin
        res = {8'd0, a[7], a[7:1]};
        c   = a[0];
      end
      cawf_pkg::OP_SWAP: res = {8'd0, a[3:0], a[7:4]};
      cawf_pkg::OP_SRL: begin
        res = {8'd0, 1'b0, a[7:1]};
        c   = a[0];
      end
      cawf_pkg::OP_BIT: begin
        res  = {8'd0, a};
        h    = 1'b1;
        mask = cawf_pkg::MASK_ZNH;
      end
      cawf_pkg::OP_RES: begin
        res  = {8'd0, a & ~bit_sel};
        mask = cawf_pkg::MASK_NONE;
      end
      cawf_pkg::OP_SET: begin
        res  = {8'd0, a | bit_sel};
        mask = cawf_pkg::MASK_NONE;
      end
      default: begin
        res  = 16'd0;
        mask = cawf_pkg::MASK_NONE;
      end
    endcase

    // Z comes from the low byte except for compare and bit test
    if (op_i.kind == cawf_pkg::OP_CP) begin
      z = (diff8[7:0] == 8'd0);
    end else if (op_i.kind == cawf_pkg::OP_BIT) begin
      z = ((a & bit_sel) == 8'd0);
    end else begin
      z = (res[7:0] == 8'd0);
    end

    // Drop unwritten flags; C shows the carry that stays in effect
    if (!mask[cawf_pkg::FLAG_Z]) z = 1'b0;
    if (!mask[cawf_pkg::FLAG_N]) n = 1'b0;
    if (!mask[cawf_pkg::FLAG_H]) h = 1'b0;
    if (!mask[cawf_pkg::FLAG_C]) c = op_i.carry_in;
  end

  assign res_o.result          = res;
  assign res_o.zero_flag       = z;
  assign res_o.subtract_flag   = n;
  assign res_o.half_carry_flag = h;
  assign res_o.carry_flag      = c;
  assign res_o.flags_written   = mask;

endmodule

// ----- hdl/cpu_alu_with_flags.sv -----
// ----------------------------------------------------------------------------
// cpu_alu_with_flags
// 8-bit ALU with Z/N/H/C flags, input register and result register.
// ----------------------------------------------------------------------------
//  channel | ports                          | beat
//  --------+--------------------------------+----------------------------
//  input   | in_valid, in_ready, in_data    | one operation (alu_in_t)
//  result  | out_valid, out_ready, out_data | value, flags, written mask
//
//  One beat per cycle sustained while out_ready holds high; an accepted beat
//  lands in the input register, then passes through the datapath to the result reg.
//  rst_n (synchronous) clears both valid bits; payload regs are not reset.
//  A stall on out_ready holds the result; the input register still takes a
//  beat while the result register is full, so in_ready drops only when both
//  stages hold beats and out_ready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cpu_alu_with_flags_defines.svh"

module cpu_alu_with_flags (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cawf_pkg::alu_in_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cawf_pkg::alu_out_t  out_data
);

  cawf_pkg::alu_in_t  op_r;
  cawf_pkg::alu_out_t res_r;
  cawf_pkg::alu_out_t res_nxt;
  logic               v1_r;
  logic               v1_nxt;
  logic               v2_r;
  logic               v2_nxt;
  logic               adv;

  // Result stage can take a beat when empty or draining
  assign adv      = !v2_r || out_ready;
  assign in_ready = !v1_r || adv;

  always_comb begin
    v1_nxt = v1_r;
    v2_nxt = v2_r;
    if (adv) v2_nxt = v1_r;
    if (in_ready) v1_nxt = in_valid;
  end

  cawf_core u_core (
    .op_i  (op_r),
    .res_o (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) op_r <= in_data;
    if (adv && v1_r) res_r <= res_nxt;
  end

  assign out_valid = v2_r;
  assign out_data  = res_r;

  `CAWF_ASSERT_NXT(a_in_lands, in_valid && in_ready, v1_r)
  `CAWF_ASSERT_NXT(a_advance, v1_r && !v2_r, v2_r)
  `CAWF_ASSERT_IMP(a_z_masked,
                   v2_r && !res_r.flags_written[cawf_pkg::FLAG_Z],
                   !res_r.zero_flag)
  `CAWF_ASSERT_IMP(a_nh_masked,
                   v2_r && (res_r.flags_written == cawf_pkg::MASK_NONE),
                   !res_r.subtract_flag && !res_r.half_carry_flag)

endmodule

// ----- test/cpu_alu_with_flags_chk.sv -----
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_chk
// Watches both channels of the ALU, computes the value, flags and written
// mask that each accepted operation must produce, and compares every result
// beat with the oldest outstanding outcome. Counts failures for the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu_alu_with_flags_chk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  cawf_pkg::alu_in_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  cawf_pkg::alu_out_t out_data,
  output int unsigned        fail_count,
  output int unsigned        pending,
  output int unsigned        checked
);

  cawf_pkg::alu_out_t outcome_q[$];
  int unsigned        issued;

  function automatic cawf_pkg::alu_out_t alu_outcome(cawf_pkg::alu_in_t op);
    logic [7:0]  a;
    logic [7:0]  b;
    logic [8:0]  sum9;
    logic [16:0] sum17;
    logic [7:0]  diff;
    logic        cy;
    logic        z;
    logic        n;
    logic        h;
    logic        c;
    logic        z_done;
    logic [3:0]  mask;
    logic [15:0] res;
    cawf_pkg::alu_out_t o;
    a      = op.operand_a[7:0];
    b      = op.operand_b[7:0];
    res    = '0;
    z      = 1'b0;
    n      = 1'b0;
    h      = 1'b0;
    c      = 1'b0;
    z_done = 1'b0;
    mask   = cawf_pkg::MASK_ALL;
    case (op.kind) inside
      cawf_pkg::OP_ADD, cawf_pkg::OP_ADC: begin
        cy   = (op.kind == cawf_pkg::OP_ADC) ? op.carry_in : 1'b0;
        sum9 = {1'b0, a} + {1'b0, b} + {8'h00, cy};
        res  = {8'h00, sum9[7:0]};
        h    = ({1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cy}) > 5'h0F;
        c    = sum9[8];
      end
      cawf_pkg::OP_SUB, cawf_pkg::OP_SBC, cawf_pkg::OP_CP: begin
        cy   = (op.kind == cawf_pkg::OP_SBC) ? op.carry_in : 1'b0;
        diff = a - b - {7'h00, cy};
        n    = 1'b1;
        h    = {1'b0, a[3:0]} < ({1'b0, b[3:0]} + {4'h0, cy});
        c    = {1'b0, a} < ({1'b0, b} + {8'h00, cy});
        if (op.kind == cawf_pkg::OP_CP) begin
          // compare flags the difference but hands back the first operand
          z      = (diff == 8'h00);
          z_done = 1'b1;
          res    = {8'h00, a};
        end else begin
          res = {8'h00, diff};
        end
      end
      cawf_pkg::OP_AND: begin
        res = {8'h00, a & b};
        h   = 1'b1;
      end
      cawf_pkg::OP_XOR: res = {8'h00, a ^ b};
      cawf_pkg::OP_OR:  res = {8'h00, a | b};
      cawf_pkg::OP_INC: begin
        h    = (a[3:0] == 4'hF);
        res  = {8'h00, a + 8'h01};
        mask = cawf_pkg::MASK_ZNH;
      end
      cawf_pkg::OP_DEC: begin
        h    = (a[3:0] == 4'h0);
        res  = {8'h00, a - 8'h01};
        n    = 1'b1;
        mask = cawf_pkg::MASK_ZNH;
      end
      cawf_pkg::OP_ADD16: begin
        sum17 = {1'b0, op.operand_a} + {1'b0, op.operand_b};
        res   = sum17[15:0];
        h     = ({1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]}) > 13'h0FFF;
        c     = sum17[16];
        mask  = cawf_pkg::MASK_NHC;
      end
      cawf_pkg::OP_RLC: begin
        c   = a[7];
        res = {8'h00, a[6:0], a[7]};
      end
      cawf_pkg::OP_RRC: begin
        c   = a[0];
        res = {8'h00, a[0], a[7:1]};
      end
      cawf_pkg::OP_RL: begin
        c   = a[7];
        res = {8'h00, a[6:0], op.carry_in};
      end
      cawf_pkg::OP_RR: begin
        c   = a[0];
        res = {8'h00, op.carry_in, a[7:1]};
      end
      cawf_pkg::OP_SLA: begin
        c   = a[7];
        res = {8'h00, a[6:0], 1'b0};
      end
      cawf_pkg::OP_SRA: begin
        c   = a[0];
        res = {8'h00, a[7], a[7:1]};
      end
      cawf_pkg::OP_SWAP: res = {8'h00, a[3:0], a[7:4]};
      cawf_pkg::OP_SRL: begin
        c   = a[0];
        res = {8'h00, 1'b0, a[7:1]};
      end
      cawf_pkg::OP_BIT: begin
        res    = {8'h00, a};
        z      = ~a[op.bit_index];
        z_done = 1'b1;
        h      = 1'b1;
        mask   = cawf_pkg::MASK_ZNH;
      end
      cawf_pkg::OP_RES: begin
        res  = {8'h00, a & ~(8'h01 << op.bit_index)};
        mask = cawf_pkg::MASK_NONE;
      end
      cawf_pkg::OP_SET: begin
        res  = {8'h00, a | (8'h01 << op.bit_index)};
        mask = cawf_pkg::MASK_NONE;
      end
      default: begin
        res  = '0;
        mask = cawf_pkg::MASK_NONE;
      end
    endcase
    if (!z_done) z = (res[7:0] == 8'h00);
    // unwritten flags read as zero, except C which shows the carry that stays
    if (!mask[cawf_pkg::FLAG_Z]) z = 1'b0;
    if (!mask[cawf_pkg::FLAG_N]) n = 1'b0;
    if (!mask[cawf_pkg::FLAG_H]) h = 1'b0;
    if (!mask[cawf_pkg::FLAG_C]) c = op.carry_in;
    o.result          = res;
    o.zero_flag       = z;
    o.subtract_flag   = n;
    o.half_carry_flag = h;
    o.carry_flag      = c;
    o.flags_written   = mask;
    return o;
  endfunction

  function automatic int unsigned field_diff(string name, logic [15:0] want, logic [15:0] got);
    if (want === got) return 0;
    $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    return 1;
  endfunction

  always @(posedge clk) begin
    cawf_pkg::alu_out_t want;
    int unsigned        bad;
    if (!rst_n) begin
      outcome_q.delete();
      fail_count <= 0;
      issued     <= 0;
      checked    <= 0;
    end else begin
      bad = 0;
      // retire first: a result never belongs to the operation taken this edge
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          bad = 1;
          $display("%0t ns: result beat %h with no operation outstanding, expected none",
                   $time, out_data);
        end else begin
          want = outcome_q.pop_front();
          bad  = field_diff("result", want.result, out_data.result)
               + field_diff("zero_flag", 16'(want.zero_flag), 16'(out_data.zero_flag))
               + field_diff("subtract_flag", 16'(want.subtract_flag),
                            16'(out_data.subtract_flag))
               + field_diff("half_carry_flag", 16'(want.half_carry_flag),
                            16'(out_data.half_carry_flag))
               + field_diff("carry_flag", 16'(want.carry_flag), 16'(out_data.carry_flag))
               + field_diff("flags_written", 16'(want.flags_written),
                            16'(out_data.flags_written));
          checked <= checked + 1;
        end
      end
      if (in_valid && in_ready) begin
        outcome_q.push_back(alu_outcome(in_data));
        issued <= issued + 1;
      end
      if (bad != 0) fail_count <= fail_count + bad;
    end
  end

  assign pending = issued - checked;

endmodule

// ----- test/cpu_alu_with_flags_tb.sv -----
// ----------------------------------------------------------------------------
// cpu_alu_with_flags_tb
// Drives the ALU with a directed set of flag corner cases and then random
// operations, with random gaps on the sender and random stalls on the
// receiver; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu_alu_with_flags_tb;

  localparam int unsigned RANDOM_OPS   = 1100;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned MAX_GAP      = 12;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [4:0]  OP_UNUSED_LO = 5'd22;
  localparam logic [4:0]  OP_UNUSED_HI = 5'd31;
  localparam int unsigned OP_LAST      = 21;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  cawf_pkg::alu_in_t  in_data;
  logic               out_valid;
  logic               out_ready;
  cawf_pkg::alu_out_t out_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;

  bit          tx_idle;
  bit          rx_idle;
  int unsigned sent;
  int unsigned kind_hits[32];

  always #2 clk = ~clk;

  cpu_alu_with_flags i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  cpu_alu_with_flags_chk i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    #2_000_000;
    $display("cpu_alu_with_flags_tb NOT OK");
    $finish;
  end

  function automatic cawf_pkg::alu_in_t mk_op(logic [4:0] kind, logic [15:0] a,
                                              logic [15:0] b, logic [2:0] bi, logic cin);
    cawf_pkg::alu_in_t op;
    op.kind      = kind;
    op.operand_a = a;
    op.operand_b = b;
    op.bit_index = bi;
    op.carry_in  = cin;
    return op;
  endfunction

  function automatic logic [15:0] pick_operand();
    logic [7:0]  byte_corner[8] = '{8'h00, 8'hFF, 8'h0F, 8'hF0, 8'h80, 8'h7F, 8'h01, 8'h10};
    logic [15:0] word_corner[6] = '{16'h0000, 16'hFFFF, 16'h0FFF, 16'hF000, 16'h8000,
                                    16'h7FFF};
    case ($urandom_range(0, 7))
      0:       return {8'($urandom), byte_corner[$urandom_range(0, 7)]};
      1:       return word_corner[$urandom_range(0, 5)];
      default: return 16'($urandom);
    endcase
  endfunction

  // sender: optional random gap, then hold valid and payload until taken
  task automatic send_op(cawf_pkg::alu_in_t op);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent = sent + 1;
    kind_hits[op.kind] = kind_hits[op.kind] + 1;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // receiver: optional random stall with ready low before each beat
  initial begin
    int unsigned gap;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  initial begin
    int unsigned covered;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    tx_idle  = 1'b0;
    rx_idle  = 1'b0;
    sent     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // flag corners per operation; high bytes are junk for 8-bit ops
    send_op(mk_op(cawf_pkg::OP_ADD,   16'hABFF, 16'h5401, 3'd0, 1'b1));
    send_op(mk_op(cawf_pkg::OP_ADC,   16'h000F, 16'hFF00, 3'd0, 1'b1));
    send_op(mk_op(cawf_pkg::OP_ADC,   16'h00FF, 16'h00FF, 3'd7, 1'b1));
    send_op(mk_op(cawf_pkg::OP_SUB,   16'h1200, 16'h3401, 3'd0, 1'b0));
    send_op(mk_op(cawf_pkg::OP_SBC,   16'h0010, 16'h000F, 3'd0, 1'b1));
    send_op(mk_op(cawf_pkg::OP_SBC,   16'h0000, 16'h00FF, 3'd0, 1'b1));
    send_op(mk_op(cawf_pkg::OP_AND,   16'hFFF0, 16'hFF0F, 3'd0, 1'b0));
    send_op(mk_op(cawf_pkg::OP_XOR,   16'h00A5, 16'hFFA5, 3'd0, 1'b1));
    send_op(mk_op(cawf_pkg::OP_OR,    16'hFF00, 16'hFF00, 3'd0, 1'b0));
    send_op(mk_op(cawf_pkg::OP_CP,    16'h7742, 16'h8842, 3'd0, 1'b1));
    send_op(mk_op(cawf_pkg::OP_INC,   16'h00FF, 16'h0000, 3'd0, 1'b1));
    send_op(mk_op(cawf_pkg::OP_INC,   16'h000F, 16'h0000, 3'd0, 1'b0));
    send_op(mk_op(cawf_pkg::OP_DEC,   16'h0001, 16'h0000, 3'd0, 1'b1));
    send_op(mk_op(cawf_pkg::OP_DEC,   16'h0010, 16'h0000, 3'd0, 1'b0));
    send_op(mk_op(cawf_pkg::OP_ADD16, 16'h0FFF, 16'h0001, 3'd0, 1'b1));
    send_op(mk_op(cawf_pkg::OP_ADD16, 16'hFFFF, 16'h0001, 3'd0, 1'b0));
    send_op(mk_op(cawf_pkg::OP_RLC,   16'h0080, 16'h0000, 3'd0, 1'b0));
    send_op(mk_op(cawf_pkg::OP_RRC,   16'h0001, 16'h0000, 3'd0, 1'b0));
    send_op(mk_op(cawf_pkg::OP_RL,    16'h0080, 16'h0000, 3'd0, 1'b1));
    send_op(mk_op(cawf_pkg::OP_RR,    16'h0001, 16'h0000, 3'd0, 1'b1));
    send_op(mk_op(cawf_pkg::OP_SLA,   16'h0080, 16'h0000, 3'd0, 1'b0));
    send_op(mk_op(cawf_pkg::OP_SRA,   16'h0081, 16'h0000, 3'd0, 1'b0));
    send_op(mk_op(cawf_pkg::OP_SWAP,  16'h00F0, 16'h0000, 3'd0, 1'b1));
    send_op(mk_op(cawf_pkg::OP_SRL,   16'h0001, 16'h0000, 3'd0, 1'b0));
    send_op(mk_op(cawf_pkg::OP_BIT,   16'h007F, 16'h0000, 3'd7, 1'b1));
    send_op(mk_op(cawf_pkg::OP_RES,   16'h00FF, 16'h0000, 3'd0, 1'b1));
    send_op(mk_op(cawf_pkg::OP_SET,   16'h0000, 16'h0000, 3'd7, 1'b0));
    send_op(mk_op(OP_UNUSED_LO, 16'hFFFF, 16'hFFFF, 3'd7, 1'b1));
    send_op(mk_op(OP_UNUSED_HI, 16'h1234, 16'h5678, 3'd3, 1'b0));
    drain();

    // idle modes cycle through none, sender, receiver, both
    for (int p = 0; p < PHASES; p++) begin
      tx_idle = p[0];
      rx_idle = p[1];
      for (int i = 0; i < RANDOM_OPS / PHASES; i++)
        send_op(mk_op(5'($urandom_range(0, OP_LAST)), pick_operand(), pick_operand(),
                      3'($urandom), 1'($urandom)));
      if (p % 3 == 2) drain();
    end
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    covered = 0;
    foreach (kind_hits[k])
      if (kind_hits[k] != 0) covered = covered + 1;
    $display("%0d operations over %0d kind codes, with sender gaps and receiver stalls;",
             sent, covered);
    $display("%0d results compared field by field, %0d failures", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("cpu_alu_with_flags_tb OK");
    end else begin
      $display("cpu_alu_with_flags_tb NOT OK");
    end
    $finish;
  end

endmodule
